FILE: hdl/dkv_pkg.sv
package dkv_pkg;

   // trellis geometry
   localparam int NUM_STATES  = 32;
   localparam int SYM_BITS    = 5;
   localparam int METRIC_BITS = 16;
   localparam int ELEM_BITS   = 6;
   localparam int CNT_BITS    = 6;

   // default sizes
   localparam int TRACEBACK_DEPTH_DEF = 16;
   localparam int SOFT_BITS_DEF       = 16;
   localparam int PATH_BITS_DEF       = 24;

   // acs pipeline: issue phase, then pipeline drain
   localparam logic [CNT_BITS-1:0] ACS_LAST_CNT  = 6'd35;
   localparam logic [CNT_BITS-1:0] ACS_ISSUE_END = 6'd32;
   localparam logic [CNT_BITS-1:0] SCAN_LAST_CNT = 6'd31;
   localparam logic [ELEM_BITS-1:0] ELEM_LAST    = 6'd63;
   localparam logic [SYM_BITS-1:0] LAST_STATE    = 5'd31;

   // second generator mapping
   localparam logic [SYM_BITS-1:0] G2_MAP [NUM_STATES] = '{
      5'd0,  5'd17, 5'd1,  5'd16, 5'd2,  5'd19, 5'd3,  5'd18,
      5'd4,  5'd21, 5'd5,  5'd20, 5'd6,  5'd23, 5'd7,  5'd22,
      5'd8,  5'd25, 5'd9,  5'd24, 5'd10, 5'd27, 5'd11, 5'd26,
      5'd12, 5'd29, 5'd13, 5'd28, 5'd14, 5'd31, 5'd15, 5'd30
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACS,
      ST_NORM,
      ST_SCAN,
      ST_ROWRD,
      ST_ROWCAP,
      ST_EMIT_STEP,
      ST_FLUSH,
      ST_LAST,
      ST_CLEAR
   } dkv_state_type;

   typedef struct packed {
      logic                 take_item;
      logic                 soft_write;
      logic [ELEM_BITS-1:0] elem_idx;
      logic                 acs_issue;
      logic [SYM_BITS-1:0]  acs_k;
      logic                 norm;
      logic                 scan;
      logic [SYM_BITS-1:0]  scan_idx;
      logic                 row_capture;
      logic                 out_load;
      logic                 out_last;
      logic [SYM_BITS-1:0]  out_entry;
      logic                 clear_block;
   } dkv_cmd_type;

   typedef struct packed {
      logic soft_mode;
      logic out_free;
   } dkv_sts_type;

   // states are visited in gray order so the metric lanes move by one bit a cycle
   function automatic logic [SYM_BITS-1:0] gray(input logic [SYM_BITS-1:0] k);
      gray = k ^ (k >> 1);
   endfunction

endpackage

FILE: hdl/dkv_ram.sv
module dkv_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dkv_ctrl.sv
module dkv_ctrl #(
   parameter int TRACEBACK_DEPTH = dkv_pkg::TRACEBACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_end_of_block,
   output logic                 req_stall,
   input  dkv_pkg::dkv_sts_type sts,
   output dkv_pkg::dkv_cmd_type cmd
);
   import dkv_pkg::*;

   localparam int SW = $clog2(TRACEBACK_DEPTH + 1);
   localparam logic [SW-1:0] DEPTH_CNT = SW'(TRACEBACK_DEPTH);
   localparam logic [SW:0]   DEPTH_P1  = (SW+1)'(TRACEBACK_DEPTH + 1);

   dkv_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ELEM_BITS-1:0] elem_ff, elem_in;
   logic [SW-1:0]        steps_ff, steps_in;
   logic [SW-1:0]        kk_ff, kk_in;
   logic                 emit_ff, emit_in;
   logic                 eob_ff, eob_in;
   logic                 take;
   logic [SW:0]          start_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign take       = req_valid && !req_stall;
   assign start_wide = DEPTH_P1 - {1'b0, steps_ff};

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         elem_ff  <= '0;
         steps_ff <= '0;
         kk_ff    <= '0;
         emit_ff  <= 1'b0;
         eob_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         elem_ff  <= elem_in;
         steps_ff <= steps_in;
         kk_ff    <= kk_in;
         emit_ff  <= emit_in;
         eob_ff   <= eob_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      elem_in  = elem_ff;
      steps_in = steps_ff;
      kk_in    = kk_ff;
      emit_in  = emit_ff;
      eob_in   = eob_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.take_item  = 1'b1;
               cmd.soft_write = sts.soft_mode;
               cmd.elem_idx   = elem_ff;
               eob_in         = req_end_of_block;
               emit_in        = 1'b0;
               cnt_in         = '0;
               if (!sts.soft_mode || elem_ff == ELEM_LAST) begin
                  elem_in  = '0;
                  emit_in  = (steps_ff == DEPTH_CNT);
                  state_in = ST_ACS;
               end else begin
                  elem_in = elem_ff + 1'b1;
                  if (req_end_of_block) begin
                     state_in = (steps_ff != '0) ? ST_SCAN : ST_CLEAR;
                  end
               end
            end
         end
         ST_ACS: begin
            cmd.acs_issue = (cnt_ff < ACS_ISSUE_END);
            cmd.acs_k     = cnt_ff[SYM_BITS-1:0];
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ACS_LAST_CNT) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            cnt_in   = '0;
            if (steps_ff != DEPTH_CNT) begin
               steps_in = steps_ff + 1'b1;
            end
            state_in = (emit_ff || eob_ff) ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.scan_idx = cnt_ff[SYM_BITS-1:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == SCAN_LAST_CNT) begin
               state_in = ST_ROWRD;
            end
         end
         ST_ROWRD: begin
            state_in = ST_ROWCAP;
         end
         ST_ROWCAP: begin
            cmd.row_capture = 1'b1;
            kk_in = (steps_ff == DEPTH_CNT) ? SW'(1) : start_wide[SW-1:0];
            if (emit_ff) begin
               state_in = ST_EMIT_STEP;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_EMIT_STEP: begin
            if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_entry = '0;
               emit_in       = 1'b0;
               state_in      = eob_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (kk_ff >= DEPTH_CNT) begin
               state_in = ST_LAST;
            end else if (sts.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_entry = SYM_BITS'(kk_ff);
               kk_in         = kk_ff + 1'b1;
            end
         end
         ST_LAST: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clear_block = 1'b1;
            steps_in        = '0;
            elem_in         = '0;
            eob_in          = 1'b0;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/dkv_datapath.sv
module dkv_datapath #(
   parameter int TRACEBACK_DEPTH = dkv_pkg::TRACEBACK_DEPTH_DEF,
   parameter int SOFT_BITS       = dkv_pkg::SOFT_BITS_DEF,
   parameter int PATH_BITS       = dkv_pkg::PATH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  logic [15:0]          req_metric,
   input  logic [4:0]           req_first_symbol,
   input  logic [4:0]           req_second_symbol,
   input  dkv_pkg::dkv_cmd_type cmd,
   output dkv_pkg::dkv_sts_type sts,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [4:0]           rsp_decoded_symbol,
   output logic                 rsp_last_of_block
);
   import dkv_pkg::*;

   localparam int NW = ((PATH_BITS > SOFT_BITS + 1) ? PATH_BITS : SOFT_BITS + 1) + 1;
   localparam int RW = TRACEBACK_DEPTH * SYM_BITS;
   localparam int KW = $clog2(TRACEBACK_DEPTH);
   localparam logic [NW-1:0] PATH_LIMIT = {{(NW-PATH_BITS){1'b0}}, {PATH_BITS{1'b1}}};

   logic                 soft_ff;
   logic [SYM_BITS-1:0]  s1_ff, s2_ff;
   logic [SOFT_BITS-1:0] lane1_ff [NUM_STATES];
   logic [SOFT_BITS-1:0] lane2_ff [NUM_STATES];
   logic [SOFT_BITS-1:0] lane1_in [NUM_STATES];
   logic [SOFT_BITS-1:0] lane2_in [NUM_STATES];
   logic [SOFT_BITS-1:0] metric_soft;
   logic [PATH_BITS-1:0] pm_ff [NUM_STATES];
   logic [NW-1:0]        nx_ff [NUM_STATES];
   logic [NW-1:0]        lo_ff;

   // acs pipeline
   logic                 a_valid_ff, a_first_ff;
   logic [SYM_BITS-1:0]  a_state_ff;
   logic [NW-1:0]        a_cand_ff [NUM_STATES];
   logic [NW-1:0]        cand_in [NUM_STATES];
   logic [SYM_BITS-1:0]  issue_state;
   logic                 b_valid_ff, b_first_ff;
   logic [SYM_BITS-1:0]  b_state_ff;
   logic [NW-1:0]        b_val_ff [4];
   logic [SYM_BITS-1:0]  b_idx_ff [4];
   logic [NW-1:0]        b_val_in [4];
   logic [SYM_BITS-1:0]  b_idx_in [4];
   logic [NW-1:0]        win_val;
   logic [SYM_BITS-1:0]  win_idx;
   logic                 c_valid_ff;
   logic [SYM_BITS-1:0]  c_state_ff, c_pred_ff;
   logic                 d_valid_ff, d_rowvld_ff;
   logic [SYM_BITS-1:0]  d_state_ff, d_pred_ff;

   // survivor banks
   logic                 sel_ff;
   logic [NUM_STATES-1:0] vld_ff [2];
   logic [SYM_BITS-1:0]  rd_addr;
   logic [RW-1:0]        rd0, rd1, rd_cur, old_row, new_row;
   logic                 wr0, wr1;

   // best state and output
   logic [SYM_BITS-1:0]  best_ff;
   logic [PATH_BITS-1:0] bestv_ff;
   logic [SYM_BITS-1:0]  rowbuf_ff [TRACEBACK_DEPTH];
   logic                 rsp_valid_ff;
   logic [SYM_BITS-1:0]  rsp_sym_ff;
   logic                 rsp_last_ff;

   generate
      if (SOFT_BITS > METRIC_BITS) begin : g_ext
         assign metric_soft = {{(SOFT_BITS-METRIC_BITS){1'b0}}, req_metric};
      end else if (SOFT_BITS == METRIC_BITS) begin : g_eq
         assign metric_soft = req_metric;
      end else begin : g_trunc
         assign metric_soft = req_metric[SOFT_BITS-1:0];
      end
   endgenerate

   assign sts.soft_mode = soft_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // metric lanes: load by element, then move along the gray order of states
   always_comb begin
      logic [SYM_BITS-1:0] step_mask;
      step_mask = gray(cmd.acs_k) ^ gray(cmd.acs_k + 1'b1);
      for (int j = 0; j < NUM_STATES; j++) begin
         lane1_in[j] = lane1_ff[j];
         lane2_in[j] = lane2_ff[j];
      end
      if (cmd.soft_write) begin
         for (int j = 0; j < NUM_STATES; j++) begin
            if (SYM_BITS'(j) == cmd.elem_idx[SYM_BITS-1:0]) begin
               if (cmd.elem_idx[SYM_BITS]) begin
                  lane2_in[j] = metric_soft;
               end else begin
                  lane1_in[j] = metric_soft;
               end
            end
         end
      end else if (cmd.acs_issue && cmd.acs_k != LAST_STATE) begin
         for (int j = 0; j < NUM_STATES; j++) begin
            for (int b = 0; b < SYM_BITS; b++) begin
               if (step_mask[b]) begin
                  lane1_in[j] = lane1_ff[SYM_BITS'(j) ^ SYM_BITS'(1 << b)];
                  lane2_in[j] = lane2_ff[SYM_BITS'(j) ^ G2_MAP[SYM_BITS'(1 << b)]];
               end
            end
         end
      end
   end

   // candidates for one next state
   assign issue_state = gray(cmd.acs_k);
   always_comb begin
      logic [SYM_BITS-1:0] g2s;
      logic [1:0]          hard_gain;
      g2s = G2_MAP[issue_state];
      for (int j = 0; j < NUM_STATES; j++) begin
         hard_gain = {1'b0, s1_ff == (issue_state ^ SYM_BITS'(j))}
                   + {1'b0, s2_ff == (g2s ^ SYM_BITS'(j))};
         if (soft_ff) begin
            cand_in[j] = NW'(pm_ff[j]) + NW'(lane1_ff[j]) + NW'(lane2_ff[j]);
         end else begin
            cand_in[j] = NW'(pm_ff[j]) + NW'(hard_gain);
         end
      end
   end

   // first select level: best of each group of eight, lowest index on ties
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         b_val_in[g] = a_cand_ff[8*g];
         b_idx_in[g] = SYM_BITS'(8*g);
         for (int m = 1; m < 8; m++) begin
            if (a_cand_ff[8*g+m] > b_val_in[g]) begin
               b_val_in[g] = a_cand_ff[8*g+m];
               b_idx_in[g] = SYM_BITS'(8*g+m);
            end
         end
      end
   end

   // second select level
   always_comb begin
      win_val = b_val_ff[0];
      win_idx = b_idx_ff[0];
      for (int g = 1; g < 4; g++) begin
         if (b_val_ff[g] > win_val) begin
            win_val = b_val_ff[g];
            win_idx = b_idx_ff[g];
         end
      end
   end

   // survivor row exchange
   assign rd_addr = c_valid_ff ? c_pred_ff : best_ff;
   assign rd_cur  = sel_ff ? rd1 : rd0;
   assign old_row = d_rowvld_ff ? rd_cur : '0;
   assign new_row = {d_pred_ff, old_row[RW-1:SYM_BITS]};
   assign wr0     = d_valid_ff && sel_ff;
   assign wr1     = d_valid_ff && !sel_ff;

   dkv_ram #(.WIDTH(RW), .DEPTH(NUM_STATES)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr0),
      .wr_addr (d_state_ff),
      .wr_data (new_row),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   dkv_ram #(.WIDTH(RW), .DEPTH(NUM_STATES)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr1),
      .wr_addr (d_state_ff),
      .wr_data (new_row),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff      <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         sel_ff       <= 1'b0;
         vld_ff[0]    <= '0;
         vld_ff[1]    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STATES; i++) begin
            pm_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            soft_ff <= csr_write_data;
         end
         a_valid_ff <= cmd.acs_issue;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         if (d_valid_ff) begin
            vld_ff[!sel_ff][d_state_ff] <= 1'b1;
         end
         // normalise by the minimum and saturate
         if (cmd.norm) begin
            sel_ff <= !sel_ff;
            for (int i = 0; i < NUM_STATES; i++) begin
               if (nx_ff[i] - lo_ff > PATH_LIMIT) begin
                  pm_ff[i] <= {PATH_BITS{1'b1}};
               end else begin
                  pm_ff[i] <= PATH_BITS'(nx_ff[i] - lo_ff);
               end
            end
         end
         if (cmd.clear_block) begin
            vld_ff[0] <= '0;
            vld_ff[1] <= '0;
            for (int i = 0; i < NUM_STATES; i++) begin
               pm_ff[i] <= '0;
            end
         end
         // result register
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         s1_ff <= req_first_symbol;
         s2_ff <= req_second_symbol;
      end
      for (int j = 0; j < NUM_STATES; j++) begin
         lane1_ff[j] <= lane1_in[j];
         lane2_ff[j] <= lane2_in[j];
      end
      a_first_ff <= (cmd.acs_k == '0);
      a_state_ff <= issue_state;
      for (int j = 0; j < NUM_STATES; j++) begin
         a_cand_ff[j] <= cand_in[j];
      end
      b_first_ff <= a_first_ff;
      b_state_ff <= a_state_ff;
      for (int g = 0; g < 4; g++) begin
         b_val_ff[g] <= b_val_in[g];
         b_idx_ff[g] <= b_idx_in[g];
      end
      // new metric and running minimum
      if (b_valid_ff) begin
         nx_ff[b_state_ff] <= win_val;
         if (b_first_ff || win_val < lo_ff) begin
            lo_ff <= win_val;
         end
      end
      c_state_ff  <= b_state_ff;
      c_pred_ff   <= win_idx;
      d_state_ff  <= c_state_ff;
      d_pred_ff   <= c_pred_ff;
      d_rowvld_ff <= vld_ff[sel_ff][c_pred_ff];
      // best state scan, first maximum wins
      if (cmd.scan) begin
         if (cmd.scan_idx == '0) begin
            best_ff  <= '0;
            bestv_ff <= pm_ff[0];
         end else if (pm_ff[cmd.scan_idx] > bestv_ff) begin
            best_ff  <= cmd.scan_idx;
            bestv_ff <= pm_ff[cmd.scan_idx];
         end
      end
      if (cmd.row_capture) begin
         for (int k = 0; k < TRACEBACK_DEPTH; k++) begin
            rowbuf_ff[k] <= vld_ff[sel_ff][best_ff] ? rd_cur[k*SYM_BITS +: SYM_BITS] : '0;
         end
      end
      if (cmd.out_load) begin
         rsp_sym_ff  <= cmd.out_last ? best_ff : rowbuf_ff[cmd.out_entry[KW-1:0]];
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;
   assign rsp_last_of_block  = rsp_last_ff;

endmodule

FILE: hdl/dual_k_viterbi_decoder_unit.sv
// hard mode: one item is one trellis step; soft mode: 64 items make one step.
// a step passes through accept, acs (one next state per cycle through a
// 4-deep select and survivor-exchange pipeline) and normalise; an emitting step adds
// a best-state scan, a survivor row read and capture, then its result.
// block end adds up to traceback_depth results, at most one per cycle.
// reset is synchronous active high: metrics and histories zero, hard mode selected.
module dual_k_viterbi_decoder_unit #(
   parameter int TRACEBACK_DEPTH = dkv_pkg::TRACEBACK_DEPTH_DEF,
   parameter int SOFT_BITS       = dkv_pkg::SOFT_BITS_DEF,
   parameter int PATH_BITS       = dkv_pkg::PATH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_metric,
   input  logic [4:0]  req_first_symbol,
   input  logic [4:0]  req_second_symbol,
   input  logic        req_end_of_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_decoded_symbol,
   output logic        rsp_last_of_block
);
   import dkv_pkg::*;

   dkv_cmd_type cmd;
   dkv_sts_type sts;

   dkv_ctrl #(.TRACEBACK_DEPTH(TRACEBACK_DEPTH)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_block (req_end_of_block),
      .req_stall        (req_stall),
      .sts              (sts),
      .cmd              (cmd)
   );

   dkv_datapath #(
      .TRACEBACK_DEPTH (TRACEBACK_DEPTH),
      .SOFT_BITS       (SOFT_BITS),
      .PATH_BITS       (PATH_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_metric         (req_metric),
      .req_first_symbol   (req_first_symbol),
      .req_second_symbol  (req_second_symbol),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_last_of_block  (rsp_last_of_block)
   );

endmodule

FILE: tb/dkv_checker.sv
module dkv_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_metric,
   input  logic [4:0]  req_first_symbol,
   input  logic [4:0]  req_second_symbol,
   input  logic        req_end_of_block,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_decoded_symbol,
   input  logic        rsp_last_of_block,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dkv_pkg::*;

   localparam int DEPTH = TRACEBACK_DEPTH_DEF;
   localparam longint unsigned METRIC_CEIL = (64'd1 << PATH_BITS_DEF) - 1;

   typedef struct packed {
      logic [4:0] symbol;
      logic       last;
   } decoded_type;

   decoded_type    decoded_queue[$];
   longint unsigned metrics[NUM_STATES];
   logic [15:0]    likelihood[64];
   logic [4:0]     history[NUM_STATES][DEPTH];
   int             steps_done;
   int             elem_count;
   logic           soft_mode;

   assign pending = decoded_queue.size();

   // start a new block
   task automatic clear_block();
      for (int i = 0; i < NUM_STATES; i++) begin
         metrics[i] = 0;
         for (int k = 0; k < DEPTH; k++) history[i][k] = '0;
      end
      steps_done = 0;
      elem_count = 0;
   endtask

   function automatic int best_state();
      int b;
      b = 0;
      for (int i = 1; i < NUM_STATES; i++)
         if (metrics[i] > metrics[b]) b = i;
      return b;
   endfunction

   // add-compare-select, normalise, register exchange
   task automatic trellis_update(logic soft_sel, logic [4:0] sym_a, logic [4:0] sym_b);
      longint unsigned nxt[NUM_STATES];
      logic [4:0]      surv[NUM_STATES];
      logic [4:0]      prior[NUM_STATES][DEPTH];
      longint unsigned cand, gain, lo;
      logic [4:0]      ia, ib;
      for (int i = 0; i < NUM_STATES; i++) begin
         nxt[i] = 0;
         surv[i] = '0;
         for (int j = 0; j < NUM_STATES; j++) begin
            ia = 5'(i) ^ 5'(j);
            ib = G2_MAP[i] ^ 5'(j);
            if (soft_sel) gain = likelihood[ia] + likelihood[32 + ib];
            else gain = (sym_a == ia) + (sym_b == ib);
            cand = metrics[j] + gain;
            if (j == 0 || cand > nxt[i]) begin
               nxt[i] = cand;
               surv[i] = 5'(j);
            end
         end
      end
      lo = nxt[0];
      for (int i = 1; i < NUM_STATES; i++)
         if (nxt[i] < lo) lo = nxt[i];
      for (int i = 0; i < NUM_STATES; i++)
         metrics[i] = (nxt[i] - lo > METRIC_CEIL) ? METRIC_CEIL : nxt[i] - lo;
      prior = history;
      for (int i = 0; i < NUM_STATES; i++) begin
         for (int k = 0; k < DEPTH - 1; k++) history[i][k] = prior[surv[i]][k + 1];
         history[i][DEPTH - 1] = surv[i];
      end
   endtask

   // work out the decoded symbols caused by one accepted item
   task automatic decode_item();
      bit         stepping;
      int         b, first;
      stepping = 0;
      if (soft_mode) begin
         likelihood[elem_count] = req_metric;
         if (elem_count == 63) begin
            elem_count = 0;
            stepping = 1;
         end else begin
            elem_count++;
         end
      end else begin
         elem_count = 0;
         stepping = 1;
      end
      if (stepping) begin
         trellis_update(soft_mode, req_first_symbol, req_second_symbol);
         if (steps_done >= DEPTH) decoded_queue.push_back('{history[best_state()][0], 1'b0});
         if (steps_done < DEPTH) steps_done++;
      end
      if (req_end_of_block) begin
         if (steps_done > 0) begin
            b = best_state();
            first = (steps_done >= DEPTH) ? 1 : DEPTH + 1 - steps_done;
            for (int k = first; k < DEPTH; k++) decoded_queue.push_back('{history[b][k], 1'b0});
            decoded_queue.push_back('{5'(b), 1'b1});
         end
         clear_block();
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         clear_block();
         soft_mode = 1'b0;
         decoded_queue.delete();
         for (int i = 0; i < 64; i++) likelihood[i] = '0;
      end else begin
         if (csr_write_enable) soft_mode = csr_write_data;
         if (req_valid && !req_stall) decode_item();
         if (rsp_valid && !rsp_stall) begin
            if (decoded_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: symbol %0d last %0b",
                           rsp_decoded_symbol, rsp_last_of_block);
            end else begin
               want = decoded_queue.pop_front();
               if (want.symbol !== rsp_decoded_symbol || want.last !== rsp_last_of_block) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected symbol %0d last %0b, got symbol %0d last %0b",
                              want.symbol, want.last, rsp_decoded_symbol, rsp_last_of_block);
               end
            end
         end
      end
   end

   initial errors = 0;

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dkv_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_metric = '0;
   logic [4:0]  req_first_symbol = '0;
   logic [4:0]  req_second_symbol = '0;
   logic        req_end_of_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_decoded_symbol;
   logic        rsp_last_of_block;
   int          errors, pending;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          cycles = 0;
   logic [4:0]  enc_state = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dual_k_viterbi_decoder_unit dut (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_stall, .req_metric, .req_first_symbol, .req_second_symbol,
      .req_end_of_block, .rsp_valid, .rsp_stall, .rsp_decoded_symbol, .rsp_last_of_block
   );

   dkv_checker u_checker (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_stall, .req_metric, .req_first_symbol, .req_second_symbol,
      .req_end_of_block, .rsp_valid, .rsp_stall, .rsp_decoded_symbol, .rsp_last_of_block,
      .errors, .pending
   );

   // receiver stalls
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // present one item and hold it until accepted
   task automatic send_item(logic [15:0] m, logic [4:0] a, logic [4:0] b, logic eob);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_metric <= m;
      req_first_symbol <= a;
      req_second_symbol <= b;
      req_end_of_block <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // encoder-like hard step, occasionally corrupted
   task automatic hard_step(logic eob, int noise_pct);
      logic [4:0] nxt, a, b;
      nxt = 5'($urandom);
      a = nxt ^ enc_state;
      b = G2_MAP[nxt] ^ enc_state;
      enc_state = nxt;
      if ($urandom_range(99) < noise_pct) a = 5'($urandom);
      if ($urandom_range(99) < noise_pct) b = 5'($urandom);
      send_item(16'($urandom), a, b, eob);
   endtask

   // count soft likelihoods toward one step (64 make a full step), strong at the encoder's symbols
   task automatic soft_step(logic eob, int count);
      logic [4:0]  nxt, a, b;
      logic [15:0] m;
      nxt = 5'($urandom);
      a = nxt ^ enc_state;
      b = G2_MAP[nxt] ^ enc_state;
      enc_state = nxt;
      for (int e = 0; e < count; e++) begin
         case ($urandom_range(9))
            0: m = 16'hffff;
            1: m = 16'h0000;
            2, 3: m = 16'($urandom);
            default: m = ((e < 32 && 5'(e) == a) || (e >= 32 && 5'(e - 32) == b)) ?
                         16'($urandom_range(40000, 65535)) : 16'($urandom_range(0, 3000));
         endcase
         send_item(m, 5'($urandom), 5'($urandom), eob && e == count - 1);
      end
   endtask

   // drain outstanding results, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_mode(logic soft_sel);
      csr_write_enable <= 1'b1;
      csr_write_data <= soft_sel;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: hard extremes and short blocks
      write_mode(1'b0);
      send_item(16'hffff, 5'd0, 5'd0, 1'b1);
      send_item(16'h0000, 5'd31, 5'd31, 1'b0);
      send_item(16'h5555, 5'd31, 5'd0, 1'b1);
      send_item(16'haaaa, 5'd0, 5'd31, 1'b0);
      send_item(16'h0000, 5'd21, 5'd10, 1'b0);
      send_item(16'hffff, 5'd10, 5'd21, 1'b1);
      for (int s = 0; s < 18; s++) hard_step(s == 17, 0);
      settle();

      // directed soft: completed step then partial step at block end, bare block end
      write_mode(1'b1);
      soft_step(1'b0, 64);
      soft_step(1'b1, 30);
      soft_step(1'b1, 1);
      settle();
      // partial soft step cut off by a switch to hard items
      soft_step(1'b0, 20);
      settle();
      write_mode(1'b0);
      hard_step(1'b0, 0);
      hard_step(1'b1, 0);
      settle();

      // random hard blocks across idle and receiver stall phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 77 : 33) : 0;
         recv_stall_pct = (p == 2) ? 77 : ((p == 3) ? 33 : 0);
         for (int blk = 0; blk < 2; blk++) begin
            len = $urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(17, 19);
            for (int s = 0; s < len; s++) hard_step(s == len - 1, $urandom_range(1) ? 10 : 60);
         end
         settle();
      end

      // random soft blocks
      write_mode(1'b1);
      for (int blk = 0; blk < 2; blk++) begin
         send_idle_pct = blk ? 33 : 77;
         recv_stall_pct = blk ? 77 : 33;
         soft_step(1'b1, 64);
         settle();
      end
      write_mode(1'b0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int s = 0; s < 20; s++) hard_step(s == 19, 20);
      settle();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/dkv_pkg.sv
hdl/dkv_ram.sv
hdl/dkv_ctrl.sv
hdl/dkv_datapath.sv
hdl/dual_k_viterbi_decoder_unit.sv
tb/dkv_checker.sv
tb/testbench.sv
